// ===== hdl/tmpr_pkg.sv =====
// Package for the tile-mode pixel renderer: field widths, codes,
// controller/datapath command and status structs.
// No dependencies; used by every other module in hdl/ except tmpr_ram.
`default_nettype none

package tmpr_pkg;

  // Memory geometry
  localparam int VRAM_BYTES    = 16384;
  localparam int VRAM_AW       = $clog2(VRAM_BYTES);
  localparam int PALETTE_BYTES = 32;
  localparam int PAL_AW        = $clog2(PALETTE_BYTES);
  localparam int DISPLAY_WIDTH = 256;

  // Field widths
  localparam int KIND_W   = 2;
  localparam int ADDR_W   = 14;
  localparam int DATA_W   = 8;
  localparam int X_W      = 9;
  localparam int Y_W      = 9;
  localparam int COLOR_W  = 8;
  localparam int BASE_W   = 3;
  localparam int HEIGHT_W = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  // Input tdata packing, lowest bits first: address, data, x, y
  localparam int ADDR_LSB = 0;
  localparam int DATA_LSB = ADDR_LSB + ADDR_W;
  localparam int X_LSB    = DATA_LSB + DATA_W;
  localparam int Y_LSB    = X_LSB + X_W;
  localparam int IN_BITS  = Y_LSB + Y_W;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((COLOR_W + 7) / 8) * 8;

  localparam logic [X_W:0] DISPLAY_WIDTH_C = (X_W + 1)'(DISPLAY_WIDTH);
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(192);

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_VRAM_WR = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PAL_WR  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY   = 2'd2;

  // Config register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NAME_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 2'd1;

  // Video memory address source
  typedef enum logic [2:0] {
    ADDR_IN,
    ADDR_NAME_LO,
    ADDR_NAME_HI,
    ADDR_PLANE_FIRST,
    ADDR_PLANE
  } addr_sel_e;

  typedef struct packed {
    logic      vram_we;
    logic      pal_we;
    logic      item_load;
    addr_sel_e addr_sel;
    logic [1:0] addr_plane;
    logic      cap_lo;
    logic      cap_tile;
    logic      cap_plane_en;
    logic [1:0] cap_plane;
    logic      out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_vram_wr;
    logic is_pal_wr;
    logic is_query;
    logic oob;
    logic slot_free;
  } ctrl_stat_t;

endpackage

`default_nettype wire

// ===== hdl/tile_mode_pixel_renderer_core.sv =====
// Top level of the tile-mode pixel renderer: controller plus datapath.
// Depends on tmpr_pkg, tmpr_ctrl, tmpr_datapath (and tmpr_ram below it).
//
//  Channel   Dir  Contents
//  s_axis    in   tuser = kind; tdata = address, data, x, y (low bits up)
//  m_axis    out  tdata = color
//  cfg       in   cfg_we_i, cfg_index_i, cfg_data_i (write only)
//
// Writes (video memory or palette) go one per cycle, back to back, while no
// query is in progress. A query keeps the input busy after its beat: name
// word low/high and four plane reads on the one video memory port, then
// taking the last plane and the palette lookup; out-of-bounds skips the reads.
// Reset loads the config defaults and clears the palette; video memory is not
// cleared. A pending result stalls only a query's last step; writes go on.
`default_nettype none

module tile_mode_pixel_renderer_core (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // [13:0] address, [21:14] data, [30:22] x, [39:31] y
  input  wire logic [tmpr_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // [1:0] kind
  input  wire logic [tmpr_pkg::KIND_W-1:0]         s_axis_tuser,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // [7:0] color
  output logic      [tmpr_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  input  wire logic                                cfg_we_i,
  input  wire logic [tmpr_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [tmpr_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  tmpr_pkg::ctrl_cmd_t  cmd;
  tmpr_pkg::ctrl_stat_t stat;

  tmpr_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  tmpr_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (s_axis_tdata),
    .in_kind_i  (s_axis_tuser),
    .out_ready_i(m_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_data_o (m_axis_tdata)
  );

  // A query beat makes the input busy on the next cycle
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == tmpr_pkg::KIND_QUERY)
    |=> !s_axis_tready)
    else $error("input still ready after a query beat");

  // Memory writes happen only on an accepted input beat
  a_write_on_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.vram_we || cmd.pal_we) |-> (s_axis_tvalid && s_axis_tready))
    else $error("memory write without an input beat");

  // A result never overwrites one that has not been taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result loaded over a pending one");

endmodule

`default_nettype wire

// ===== hdl/tmpr_ram.sv =====
// Generic single-port RAM: one write or read per cycle, registered read.
// No dependencies.
`default_nettype none

module tmpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hdl/tmpr_ctrl.sv =====
// Sequencer for the pixel renderer: walks a query through the name-word,
// pattern-plane and palette steps. Depends on tmpr_pkg.
`default_nettype none

module tmpr_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire tmpr_pkg::ctrl_stat_t stat_i,
  output tmpr_pkg::ctrl_cmd_t      cmd_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_NLO  = 3'd1;  // issue name word low byte
  localparam logic [2:0] ST_NHI  = 3'd2;  // issue high byte, take low
  localparam logic [2:0] ST_P0   = 3'd3;  // take high byte, issue plane 0
  localparam logic [2:0] ST_P1   = 3'd4;
  localparam logic [2:0] ST_P2   = 3'd5;
  localparam logic [2:0] ST_P3   = 3'd6;
  localparam logic [2:0] ST_OUT  = 3'd7;  // last plane in, wait for slot

  logic [2:0] state_q, state_d;
  logic       idx_done_q, idx_done_d;
  logic       beat_in;

  assign in_ready_o = (state_q == ST_IDLE);
  assign beat_in    = in_valid_i && in_ready_o;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    idx_done_d = idx_done_q;
    cmd_o      = '0;
    cmd_o.addr_sel = tmpr_pkg::ADDR_IN;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.vram_we   = beat_in && stat_i.is_vram_wr;
        cmd_o.pal_we    = beat_in && stat_i.is_pal_wr;
        cmd_o.item_load = beat_in && stat_i.is_query;
        if (beat_in && stat_i.is_query) begin
          state_d    = stat_i.oob ? ST_OUT : ST_NLO;
          idx_done_d = stat_i.oob;
        end
      end
      ST_NLO: begin
        cmd_o.addr_sel = tmpr_pkg::ADDR_NAME_LO;
        state_d = ST_NHI;
      end
      ST_NHI: begin
        cmd_o.addr_sel = tmpr_pkg::ADDR_NAME_HI;
        cmd_o.cap_lo   = 1'b1;
        state_d = ST_P0;
      end
      ST_P0: begin
        cmd_o.addr_sel   = tmpr_pkg::ADDR_PLANE_FIRST;
        cmd_o.addr_plane = 2'd0;
        cmd_o.cap_tile   = 1'b1;
        state_d = ST_P1;
      end
      ST_P1: begin
        cmd_o.addr_sel     = tmpr_pkg::ADDR_PLANE;
        cmd_o.addr_plane   = 2'd1;
        cmd_o.cap_plane_en = 1'b1;
        cmd_o.cap_plane    = 2'd0;
        state_d = ST_P2;
      end
      ST_P2: begin
        cmd_o.addr_sel     = tmpr_pkg::ADDR_PLANE;
        cmd_o.addr_plane   = 2'd2;
        cmd_o.cap_plane_en = 1'b1;
        cmd_o.cap_plane    = 2'd1;
        state_d = ST_P3;
      end
      ST_P3: begin
        cmd_o.addr_sel     = tmpr_pkg::ADDR_PLANE;
        cmd_o.addr_plane   = 2'd3;
        cmd_o.cap_plane_en = 1'b1;
        cmd_o.cap_plane    = 2'd2;
        state_d    = ST_OUT;
        idx_done_d = 1'b0;
      end
      ST_OUT: begin
        // plane 3 is taken on entry from ST_P3, only once
        cmd_o.addr_sel     = tmpr_pkg::ADDR_PLANE;
        cmd_o.addr_plane   = 2'd3;
        cmd_o.cap_plane_en = !idx_done_q;
        cmd_o.cap_plane    = 2'd3;
        idx_done_d         = 1'b1;
        if (idx_done_q && stat_i.slot_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      idx_done_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      idx_done_q <= idx_done_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/tmpr_datapath.sv =====
// Datapath of the pixel renderer: config registers, video memory, palette,
// name/pattern capture and the output register. Depends on tmpr_pkg, tmpr_ram.
`default_nettype none

module tmpr_datapath (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire tmpr_pkg::ctrl_cmd_t                 cmd_i,
  output tmpr_pkg::ctrl_stat_t                     stat_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [tmpr_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [tmpr_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  wire logic [tmpr_pkg::IN_TDATA_W-1:0]     in_data_i,
  input  wire logic [tmpr_pkg::KIND_W-1:0]         in_kind_i,
  input  wire logic                                out_ready_i,
  output logic                                     out_valid_o,
  output logic      [tmpr_pkg::OUT_TDATA_W-1:0]    out_data_o
);

  localparam int AW = tmpr_pkg::VRAM_AW;

  logic [tmpr_pkg::BASE_W-1:0]   base_q;
  logic [tmpr_pkg::HEIGHT_W-1:0] height_q;

  logic [tmpr_pkg::ADDR_W-1:0] in_addr;
  logic [tmpr_pkg::DATA_W-1:0] in_byte;
  logic [tmpr_pkg::X_W-1:0]    in_x;
  logic [tmpr_pkg::Y_W-1:0]    in_y;

  logic [tmpr_pkg::X_W-1:0] x_q;
  logic [tmpr_pkg::Y_W-1:0] y_q;
  logic                     zero_q;
  logic [7:0]               lo_q;
  logic [8:0]               tile_q;
  logic                     upper_q;
  logic [3:0]               idx_q;

  logic [AW-1:0] name_addr, vram_addr;
  logic [8:0]    tile_src;
  logic [7:0]    rdata;
  logic [2:0]    bit_sel;

  logic [tmpr_pkg::DATA_W-1:0] pal_q [tmpr_pkg::PALETTE_BYTES];

  logic                         out_valid_q;
  logic [tmpr_pkg::COLOR_W-1:0] color_q;

  // Field unpack
  assign in_addr = in_data_i[tmpr_pkg::ADDR_LSB +: tmpr_pkg::ADDR_W];
  assign in_byte = in_data_i[tmpr_pkg::DATA_LSB +: tmpr_pkg::DATA_W];
  assign in_x    = in_data_i[tmpr_pkg::X_LSB +: tmpr_pkg::X_W];
  assign in_y    = in_data_i[tmpr_pkg::Y_LSB +: tmpr_pkg::Y_W];

  // Status to the controller
  assign stat_o.is_vram_wr = (in_kind_i == tmpr_pkg::KIND_VRAM_WR);
  assign stat_o.is_pal_wr  = (in_kind_i == tmpr_pkg::KIND_PAL_WR);
  assign stat_o.is_query   = (in_kind_i == tmpr_pkg::KIND_QUERY);
  assign stat_o.oob        = ({1'b0, in_x} >= tmpr_pkg::DISPLAY_WIDTH_C) ||
                             (in_y >= height_q);
  assign stat_o.slot_free  = !out_valid_q || out_ready_i;

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= '0;
      height_q <= tmpr_pkg::HEIGHT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        tmpr_pkg::REG_NAME_BASE: base_q   <= cfg_data_i[tmpr_pkg::BASE_W-1:0];
        tmpr_pkg::REG_HEIGHT:    height_q <= cfg_data_i[tmpr_pkg::HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Name word address: base*2 KiB + row*64 + col*2, wraps at memory size.
  // Low bit is always clear, so the high byte sits at name_addr | 1.
  assign name_addr = {base_q, 11'd0}
                   + {{(AW - 12){1'b0}}, y_q[8:3], 6'd0}
                   + {{(AW - 6){1'b0}}, x_q[7:3], 1'b0};

  // Plane 0 address uses the high name byte straight off the read port
  assign tile_src = (cmd_i.addr_sel == tmpr_pkg::ADDR_PLANE_FIRST) ?
                    {rdata[0], lo_q} : tile_q;

  always_comb begin
    case (cmd_i.addr_sel)
      tmpr_pkg::ADDR_NAME_LO:     vram_addr = name_addr;
      tmpr_pkg::ADDR_NAME_HI:     vram_addr = {name_addr[AW-1:1], 1'b1};
      tmpr_pkg::ADDR_PLANE_FIRST,
      tmpr_pkg::ADDR_PLANE:       vram_addr = {tile_src, y_q[2:0], cmd_i.addr_plane};
      default:                    vram_addr = in_addr;
    endcase
  end

  tmpr_ram #(
    .WIDTH(tmpr_pkg::DATA_W),
    .DEPTH(tmpr_pkg::VRAM_BYTES)
  ) u_vram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.vram_we),
    .addr_i (vram_addr),
    .wdata_i(in_byte),
    .rdata_o(rdata)
  );

  // Palette, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < tmpr_pkg::PALETTE_BYTES; i++) begin
        pal_q[i] <= '0;
      end
    end else if (cmd_i.pal_we) begin
      pal_q[in_addr[tmpr_pkg::PAL_AW-1:0]] <= in_byte;
    end
  end

  // Query capture: pixel bit 7 - x%8 of each plane
  assign bit_sel = ~x_q[2:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.item_load) begin
      x_q <= in_x;
      y_q <= in_y;
    end
    if (cmd_i.cap_lo) begin
      lo_q <= rdata;
    end
    if (cmd_i.cap_tile) begin
      tile_q  <= {rdata[0], lo_q};
      upper_q <= rdata[3];
    end
    if (cmd_i.cap_plane_en) begin
      idx_q[cmd_i.cap_plane] <= rdata[bit_sel];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_q <= 1'b0;
    end else if (cmd_i.item_load) begin
      zero_q <= stat_o.oob;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      color_q <= zero_q ? '0 : pal_q[{upper_q, idx_q}];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = tmpr_pkg::OUT_TDATA_W'(color_q);

endmodule

`default_nettype wire

// ===== dv/tmpr_tb_pkg.sv =====
// Testbench package for the tile-mode pixel renderer: the item struct and
// a color tracker holding its own copy of video memory, palette and registers.
// Depends on tmpr_pkg.
package tmpr_tb_pkg;

  import tmpr_pkg::*;

  // One input beat: tuser = kind, tdata = {y, x, data, address}
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] data;
    logic [X_W-1:0]    x;
    logic [Y_W-1:0]    y;
  } pixel_item_t;

  // Kind code the block drops without a result
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  // Register indexes that map to nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  localparam int REPORT_LIMIT = 10;

  class pixel_color_tracker;
    bit [DATA_W-1:0]   vram [VRAM_BYTES];
    bit                vram_written [VRAM_BYTES];
    bit [COLOR_W-1:0]  palette [PALETTE_BYTES];
    bit [BASE_W-1:0]   name_base = '0;
    bit [HEIGHT_W-1:0] height = HEIGHT_RESET;
    logic [COLOR_W-1:0] pending_colors [$];
    int failures = 0;

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_NAME_BASE: name_base = value[BASE_W-1:0];
        REG_HEIGHT:    height = value[HEIGHT_W-1:0];
        default: ;
      endcase
    endfunction

    function bit visible(logic [X_W-1:0] x, logic [Y_W-1:0] y);
      return (int'(x) < DISPLAY_WIDTH) && (y < height);
    endfunction

    // Name-table entry: 2 KiB base, 64 bytes per tile row, 2 bytes per entry
    function logic [ADDR_W-1:0] name_addr(logic [X_W-1:0] x, logic [Y_W-1:0] y);
      int a;
      a = int'(name_base) * 2048 + int'(y >> 3) * 64 + int'(x >> 3) * 2;
      return ADDR_W'(a % VRAM_BYTES);
    endfunction

    function logic [15:0] name_word(logic [X_W-1:0] x, logic [Y_W-1:0] y);
      logic [ADDR_W-1:0] na;
      na = name_addr(x, y);
      return {vram[ADDR_W'(na + 1)], vram[na]};
    endfunction

    // First of the four plane bytes of the pixel's tile row
    function logic [ADDR_W-1:0] row_addr(logic [X_W-1:0] x, logic [Y_W-1:0] y);
      logic [15:0] word;
      word = name_word(x, y);
      return ADDR_W'(int'(word[8:0]) * 32 + int'(y[2:0]) * 4);
    endfunction

    function logic [COLOR_W-1:0] predict_color(logic [X_W-1:0] x, logic [Y_W-1:0] y);
      logic [15:0]       word;
      logic [ADDR_W-1:0] ra;
      logic [2:0]        bitpos;
      logic [3:0]        idx;
      if (!visible(x, y)) return '0;
      word = name_word(x, y);
      ra = row_addr(x, y);
      bitpos = 3'd7 - x[2:0];
      for (int p = 0; p < 4; p++) idx[p] = vram[ADDR_W'(int'(ra) + p)][bitpos];
      // bit 11 of the name word picks the upper palette half
      return palette[{word[11], idx}];
    endfunction

    function void note_item(pixel_item_t it);
      case (it.kind)
        KIND_VRAM_WR: begin
          vram[it.address] = it.data;
          vram_written[it.address] = 1'b1;
        end
        KIND_PAL_WR: palette[it.address[PAL_AW-1:0]] = it.data;
        KIND_QUERY:  pending_colors.push_back(predict_color(it.x, it.y));
        default: ;
      endcase
    endfunction

    function void check_color(logic [COLOR_W-1:0] got);
      logic [COLOR_W-1:0] want;
      if (pending_colors.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT) $display("color beat %02h with nothing pending", got);
        return;
      end
      want = pending_colors.pop_front();
      if (got !== want) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("color mismatch: expected %02h, got %02h", want, got);
      end
    endfunction

    function bit all_clear();
      if (pending_colors.size() != 0) begin
        failures++;
        $display("%0d expected colors never came out", pending_colors.size());
      end
      return failures == 0;
    endfunction
  endclass

endpackage

// ===== dv/tb_tile_mode_pixel_renderer_core.sv =====
// Top-level testbench for tile_mode_pixel_renderer_core: directed and random
// memory writes and pixel queries, results checked against the color tracker.
// Depends on tmpr_pkg, tmpr_tb_pkg and the RTL under hdl/.
module tb_tile_mode_pixel_renderer_core;

  timeunit 1ns;
  timeprecision 1ps;

  import tmpr_pkg::*;
  import tmpr_tb_pkg::*;

  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int SETTLE_CYCLES   = 16;
  localparam int ITEMS_PER_PHASE = 200;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [KIND_W-1:0]      s_axis_tuser  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i    = '0;

  pixel_color_tracker colors;
  bit                 send_steady = 1'b0;
  int unsigned        cycles = 0;
  int                 sent_items = 0;

  tile_mode_pixel_renderer_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic pixel_item_t random_item(logic [KIND_W-1:0] kind);
    pixel_item_t it;
    logic [63:0] r;
    r = {$urandom, $urandom};
    it = r[$bits(pixel_item_t)-1:0];
    it.kind = kind;
    return it;
  endfunction

  // Drive one beat after a random gap; valid stays up for a back-to-back beat
  task automatic send_item(pixel_item_t it);
    int gap;
    gap = send_steady ? 0 : $urandom_range(0, 5);
    if ($urandom_range(0, 59) == 0) send_steady = !send_steady;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.kind;
    s_axis_tdata  <= {it.y, it.x, it.data, it.address};
    do @(posedge clk_i); while (!s_axis_tready);
    colors.note_item(it);
    sent_items++;
  endtask

  // Stop sending until every pending color is back, then idle a while
  task automatic pause_sender(int settle);
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (colors.pending_colors.size() != 0);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_regs(logic [CFG_DATA_W-1:0] base_val, logic [CFG_DATA_W-1:0] height_val,
                            bit touch_spare);
    logic [CFG_DATA_W-1:0] junk;
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_NAME_BASE;
    cfg_data_i  <= base_val;
    @(posedge clk_i);
    colors.write_reg(REG_NAME_BASE, base_val);
    cfg_index_i <= REG_HEIGHT;
    cfg_data_i  <= height_val;
    @(posedge clk_i);
    colors.write_reg(REG_HEIGHT, height_val);
    if (touch_spare) begin
      junk = CFG_DATA_W'($urandom);
      cfg_index_i <= REG_SPARE_A;
      cfg_data_i  <= junk;
      @(posedge clk_i);
      colors.write_reg(REG_SPARE_A, junk);
      cfg_index_i <= REG_SPARE_B;
      cfg_data_i  <= ~junk;
      @(posedge clk_i);
      colors.write_reg(REG_SPARE_B, ~junk);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic write_vram(logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d);
    pixel_item_t it;
    it = random_item(KIND_VRAM_WR);
    it.address = a;
    it.data = d;
    send_item(it);
  endtask

  task automatic write_palette(logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d);
    pixel_item_t it;
    it = random_item(KIND_PAL_WR);
    it.address = a;
    it.data = d;
    send_item(it);
  endtask

  // Random byte into a video memory location that was never written
  task automatic fill_byte(logic [ADDR_W-1:0] a);
    if (!colors.vram_written[a]) write_vram(a, DATA_W'($urandom));
  endtask

  // Query a pixel, first seeding any name or pattern byte it would read
  task automatic query_pixel(logic [X_W-1:0] x, logic [Y_W-1:0] y);
    pixel_item_t       it;
    logic [ADDR_W-1:0] na;
    logic [ADDR_W-1:0] ra;
    if (colors.visible(x, y)) begin
      na = colors.name_addr(x, y);
      fill_byte(na);
      fill_byte(ADDR_W'(na + 1));
      ra = colors.row_addr(x, y);
      for (int p = 0; p < 4; p++) fill_byte(ADDR_W'(int'(ra) + p));
    end
    it = random_item(KIND_QUERY);
    it.x = x;
    it.y = y;
    send_item(it);
  endtask

  // Random traffic until count more beats have gone in, seeding writes included
  task automatic run_random(int count);
    int                roll;
    int                start;
    logic [X_W-1:0]    rx;
    logic [Y_W-1:0]    ry;
    pixel_item_t       it;
    start = sent_items;
    while (sent_items - start < count) begin
      roll = $urandom_range(0, 99);
      rx = X_W'($urandom_range(0, DISPLAY_WIDTH - 1));
      ry = (colors.height == 0) ? Y_W'($urandom_range(0, 511))
                                : Y_W'($urandom_range(0, colors.height - 1));
      if (roll < 45) begin
        query_pixel(rx, ry);
      end else if (roll < 55) begin
        query_pixel(X_W'($urandom), Y_W'($urandom));
      end else if (roll < 68) begin
        send_item(random_item(KIND_VRAM_WR));
      end else if (roll < 80) begin
        // retarget a name entry of the visible area
        write_vram(ADDR_W'(colors.name_addr(rx, ry) + $urandom_range(0, 1)),
                   DATA_W'($urandom));
      end else if (roll < 92) begin
        send_item(random_item(KIND_PAL_WR));
      end else if (roll < 97) begin
        send_item(random_item(KIND_UNUSED));
      end else begin
        pause_sender(0);
      end
    end
  endtask

  // Result side: random stall after each color beat, with steady stretches
  initial begin : result_sink
    int hold;
    bit steady;
    hold = 0;
    steady = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        colors.check_color(m_axis_tdata[COLOR_W-1:0]);
        if ($urandom_range(0, 39) == 0) steady = !steady;
        hold = steady ? 0 : $urandom_range(0, 5);
      end else if (hold > 0) begin
        hold--;
      end
      m_axis_tready <= (hold == 0);
    end
  end

  initial begin : stimulus
    pixel_item_t it;
    colors = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Palette: only the low five address bits select the entry
    write_palette(14'h3FE0, 8'hFF);
    write_palette(14'h001F, 8'h81);
    write_palette(14'h2015, 8'hA5);
    write_palette(14'h0010, 8'h00);
    // Name entry (0,0): all ones -> tile 511, upper palette half
    write_vram(14'h0000, 8'hFF);
    write_vram(14'h0001, 8'hFF);
    // Tile 511 row 0 sits at the very top of video memory
    write_vram(14'h3FE0, 8'hFF);
    write_vram(14'h3FE1, 8'h00);
    write_vram(14'h3FE2, 8'hFF);
    write_vram(14'h3FE3, 8'h00);
    query_pixel(9'd0, 9'd0);
    query_pixel(9'd7, 9'd0);
    // Next name entry, seeded at random; low tiles overlap the name table at base 0
    query_pixel(9'd8, 9'd0);
    query_pixel(9'd255, 9'd191);
    // Outside the visible area
    query_pixel(9'd256, 9'd0);
    query_pixel(9'd511, 9'd511);
    query_pixel(9'd0, 9'd192);
    query_pixel(9'd255, 9'd192);
    // Unused kind with every field bit set
    it = '1;
    send_item(it);
    run_random(ITEMS_PER_PHASE);

    // Highest base, every line but 511 visible; upper data bits of the base dropped
    pause_sender(SETTLE_CYCLES);
    write_regs(9'h1FF, 9'h1FF, 1'b1);
    // Name-table address runs past the end of video memory
    query_pixel(9'd248, 9'd504);
    query_pixel(9'd255, 9'd511);
    run_random(ITEMS_PER_PHASE);

    // Nothing visible
    pause_sender(SETTLE_CYCLES);
    write_regs(9'h003, 9'h000, 1'b0);
    query_pixel(9'd0, 9'd0);
    run_random(ITEMS_PER_PHASE);

    // Single visible line
    pause_sender(SETTLE_CYCLES);
    write_regs(9'h005, 9'h001, 1'b1);
    query_pixel(9'd0, 9'd0);
    query_pixel(9'd0, 9'd1);
    run_random(ITEMS_PER_PHASE);

    // Back to the reset values
    pause_sender(SETTLE_CYCLES);
    write_regs(9'h000, 9'd192, 1'b0);
    run_random(ITEMS_PER_PHASE);

    for (int ph = 0; ph < 4; ph++) begin
      pause_sender(SETTLE_CYCLES);
      write_regs(CFG_DATA_W'($urandom),
                 ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom_range(0, 15))
                                             : CFG_DATA_W'($urandom_range(128, 511)),
                 ph[0]);
      run_random(ITEMS_PER_PHASE);
    end

    pause_sender(SETTLE_CYCLES);
    if (colors.all_clear()) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/tmpr_pkg.sv
hdl/tmpr_ram.sv
hdl/tmpr_ctrl.sv
hdl/tmpr_datapath.sv
hdl/tile_mode_pixel_renderer_core.sv
dv/tmpr_tb_pkg.sv
dv/tb_tile_mode_pixel_renderer_core.sv
